>>> rtl/core/srcfp_pkg.sv
package srcfp_pkg;

  localparam int PAYLOAD_BYTES = 22;
  localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * 8;
  localparam int NUM_CHANNELS  = 16;
  localparam int CHANNEL_WIDTH = 11;
  localparam int LOST_WIDTH    = 32;

  localparam logic [7:0] RC_MIN_LENGTH  = 8'd24;
  localparam logic [7:0] MIN_LENGTH     = 8'd2;
  localparam logic [7:0] CRC_POLY       = 8'hD5;
  localparam logic [7:0] SYNC_RESET     = 8'hC8;
  localparam logic [5:0] MAX_LEN_RESET  = 6'd62;
  localparam logic [7:0] RC_TYPE_RESET  = 8'h16;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SYNC_ADDRESS     = 2'd0;
  localparam logic [1:0] CFG_MAX_FRAME_LENGTH = 2'd1;
  localparam logic [1:0] CFG_RC_FRAME_TYPE    = 2'd2;

  typedef enum logic [1:0] {
    STATUS_CHANNEL   = 2'd0,
    STATUS_CRC_ERROR = 2'd1,
    STATUS_OTHER     = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] sync_address;
    logic [5:0] max_frame_length;
    logic [7:0] rc_frame_type;
  } cfg_t;

  // A frame that just finished, handed from the parser to the result buffer.
  typedef struct packed {
    logic                    valid;
    status_t                 status;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [LOST_WIDTH-1:0]   lost;
  } frame_done_t;

  // One byte of CRC-8, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/core/srcfp_parser.sv
module srcfp_parser #(
  parameter int LOST_COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srcfp_pkg::cfg_t      cfg,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  input  logic                 resync,
  output logic                 crc_next,
  output srcfp_pkg::frame_done_t done
);

  logic [6:0]                  count_r, count_nxt;
  logic [5:0]                  len_r, len_nxt;
  logic [7:0]                  crc_r, crc_nxt;
  logic [7:0]                  type_r, type_nxt;
  logic [LOST_COUNT_WIDTH-1:0] lost_r, lost_nxt;
  logic [7:0]                  payload_r [srcfp_pkg::PAYLOAD_BYTES];
  logic                        store_en;
  logic [4:0]                  store_idx;
  logic [6:0]                  len_plus;

  assign len_plus  = {1'b0, len_r} + 7'd1;
  // The CRC byte sits one place past the length byte's count.
  assign crc_next  = (count_r >= 7'd2) && (count_r == len_plus);
  assign store_idx = 5'(count_r - 7'd3);

  always_comb begin
    count_nxt   = count_r;
    len_nxt     = len_r;
    crc_nxt     = crc_r;
    type_nxt    = type_r;
    lost_nxt    = lost_r;
    store_en    = 1'b0;
    done.valid  = 1'b0;
    done.status = srcfp_pkg::STATUS_OTHER;
    if (accept) begin
      if (resync) begin
        count_nxt = 7'd0;
      end else if (count_r == 7'd0) begin
        if (rx_byte == cfg.sync_address) begin
          count_nxt = 7'd1;
          crc_nxt   = 8'd0;
          type_nxt  = 8'd0;
          len_nxt   = 6'd0;
        end
      end else if (count_r == 7'd1) begin
        if (rx_byte < srcfp_pkg::MIN_LENGTH || rx_byte > {2'b00, cfg.max_frame_length}) begin
          count_nxt = 7'd0;
        end else begin
          len_nxt   = rx_byte[5:0];
          count_nxt = 7'd2;
        end
      end else if (!crc_next) begin
        count_nxt = count_r + 7'd1;
        if (count_r == 7'd2) begin
          type_nxt = rx_byte;
        end else if (count_r <= 7'd24) begin
          store_en = 1'b1;
        end
        crc_nxt = srcfp_pkg::crc8_step(crc_r, rx_byte);
      end else begin
        count_nxt  = 7'd0;
        done.valid = 1'b1;
        if (rx_byte != crc_r) begin
          lost_nxt    = lost_r + LOST_COUNT_WIDTH'(1);
          done.status = srcfp_pkg::STATUS_CRC_ERROR;
        end else if (type_r != cfg.rc_frame_type ||
                     {2'b00, len_r} < srcfp_pkg::RC_MIN_LENGTH) begin
          done.status = srcfp_pkg::STATUS_OTHER;
        end else begin
          done.status = srcfp_pkg::STATUS_CHANNEL;
        end
      end
    end
    done.lost = 32'(lost_nxt);
    for (int i = 0; i < srcfp_pkg::PAYLOAD_BYTES; i++) begin
      done.payload[8*i +: 8] = payload_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 7'd0;
      len_r   <= 6'd0;
      crc_r   <= 8'd0;
      type_r  <= 8'd0;
      lost_r  <= '0;
    end else begin
      count_r <= count_nxt;
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
      type_r  <= type_nxt;
      lost_r  <= lost_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      payload_r[store_idx] <= rx_byte;
    end
  end

  a_count_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= 7'd2) |-> (count_r <= len_plus))
    else $error("byte count ran past the frame's CRC byte");

  a_done_on_crc: assert property (@(posedge clk) disable iff (!rst_n)
    done.valid |-> (accept && !resync && crc_next))
    else $error("frame finished away from its CRC byte");

endmodule

>>> rtl/core/srcfp_emitter.sv
module srcfp_emitter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  srcfp_pkg::frame_done_t done,
  output logic                  busy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [3:0]            out_channel_index,
  output logic [10:0]           out_channel_value,
  output logic                  out_last_of_frame,
  output logic [31:0]           out_lost_frames
);

  logic [4:0]                              cnt_r;
  logic [3:0]                              idx_r;
  srcfp_pkg::status_t                      status_r;
  logic [srcfp_pkg::PAYLOAD_BITS-1:0]      data_r;
  logic [srcfp_pkg::LOST_WIDTH-1:0]        lost_r;
  logic                                    pop;
  logic                                    is_channel;

  assign busy       = (cnt_r != 5'd0);
  assign out_valid  = busy;
  assign pop        = out_valid && out_ready;
  assign is_channel = (status_r == srcfp_pkg::STATUS_CHANNEL);

  assign out_status        = status_r;
  assign out_channel_index = is_channel ? idx_r : 4'd0;
  assign out_channel_value = is_channel ? data_r[srcfp_pkg::CHANNEL_WIDTH-1:0] : 11'd0;
  assign out_last_of_frame = (cnt_r == 5'd1);
  assign out_lost_frames   = lost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 5'd0;
      idx_r <= 4'd0;
    end else if (done.valid) begin
      cnt_r <= (done.status == srcfp_pkg::STATUS_CHANNEL) ?
               5'(srcfp_pkg::NUM_CHANNELS) : 5'd1;
      idx_r <= 4'd0;
    end else if (pop) begin
      cnt_r <= cnt_r - 5'd1;
      idx_r <= idx_r + 4'd1;
    end
  end

  // Channels are packed LSB first, so each word takes the low 11 bits and shifts.
  always_ff @(posedge clk) begin
    if (done.valid) begin
      status_r <= done.status;
      data_r   <= done.payload;
      lost_r   <= done.lost;
    end else if (pop) begin
      data_r <= data_r >> srcfp_pkg::CHANNEL_WIDTH;
    end
  end

  a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    done.valid |-> (cnt_r == 5'd0))
    else $error("new frame arrived while results were still pending");

  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !is_channel) |-> (cnt_r == 5'd1))
    else $error("error or other frame holds more than one word");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && out_last_of_frame && !done.valid) |=> !out_valid)
    else $error("output stayed valid after the last word was taken");

endmodule

>>> rtl/core/serial_rc_frame_parser.sv
// Serial RC frame parser: takes one received byte per cycle, hunts for the
// configured address byte, checks the length byte, runs a CRC-8 (poly 0xD5)
// over type and payload, and at the CRC byte reports the frame. A CRC failure
// gives one error word and bumps the wrapping lost-frame count; a good RC
// channels frame of length 24 or more gives sixteen words, one 11-bit channel
// each; any other good frame gives one word. Input bytes are taken every cycle.
// The only stall is on a frame's CRC byte while words of the previous frame
// are still waiting in the result buffer, which drains at one word per cycle
// while the receiver is ready; the CRC byte goes in the cycle after the last
// word leaves. A frame that follows a sixteen-word frame therefore finishes
// only after all sixteen words of that frame have been taken.
module serial_rc_frame_parser #(
  parameter int LOST_COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_resync,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_channel_index,
  output logic [10:0] out_channel_value,
  output logic        out_last_of_frame,
  output logic [31:0] out_lost_frames
);

  srcfp_pkg::cfg_t        cfg_r;
  srcfp_pkg::frame_done_t done;
  logic                   crc_next;
  logic                   busy;
  logic                   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_address     <= srcfp_pkg::SYNC_RESET;
      cfg_r.max_frame_length <= srcfp_pkg::MAX_LEN_RESET;
      cfg_r.rc_frame_type    <= srcfp_pkg::RC_TYPE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        srcfp_pkg::CFG_SYNC_ADDRESS:     cfg_r.sync_address     <= cfg_wdata;
        srcfp_pkg::CFG_MAX_FRAME_LENGTH: cfg_r.max_frame_length <= cfg_wdata[5:0];
        srcfp_pkg::CFG_RC_FRAME_TYPE:    cfg_r.rc_frame_type    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold off only the byte that would finish a frame while the buffer still holds words.
  assign in_ready = !(crc_next && busy);
  assign accept   = in_valid && in_ready;

  srcfp_parser #(
    .LOST_COUNT_WIDTH(LOST_COUNT_WIDTH)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .accept   (accept),
    .rx_byte  (in_rx_byte),
    .resync   (in_resync),
    .crc_next (crc_next),
    .done     (done)
  );

  srcfp_emitter u_emitter (
    .clk               (clk),
    .rst_n             (rst_n),
    .done              (done),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_last_of_frame (out_last_of_frame),
    .out_lost_frames   (out_lost_frames)
  );

  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no words pending");

endmodule
